>>> rtl/core/srd24_pkg.sv
// ----------------------------------------------------------------------------
// srd24_pkg
// Shared types and constants for the 24-bit sample record deframer.
// ----------------------------------------------------------------------------
package srd24_pkg;

  localparam int unsigned BYTES_PER_SAMPLE = 3;
  localparam int unsigned PREFIX_BYTES     = 3;
  localparam int unsigned CFG_DATA_W       = 24;
  localparam int unsigned CFG_IDX_W        = 3;
  localparam int unsigned ENABLE_BITS      = 16;

  localparam logic [7:0]             HEADER_SKIP_RST    = 8'd0;
  localparam logic [23:0]            FIRST_RECORD_RST   = 24'd0;
  localparam logic [23:0]            RECORD_COUNT_RST   = 24'd1;
  localparam logic [4:0]             NUM_CHANNELS_RST   = 5'd16;
  localparam logic [ENABLE_BITS-1:0] CHANNEL_ENABLE_RST = 16'hFFFF;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_HEADER_SKIP    = 3'd0,
    REG_FIRST_RECORD   = 3'd1,
    REG_RECORD_COUNT   = 3'd2,
    REG_NUM_CHANNELS   = 3'd3,
    REG_CHANNEL_ENABLE = 3'd4
  } reg_idx_t;

  typedef struct packed {
    logic [7:0]             header_skip;
    logic [23:0]            first_record;
    logic [23:0]            record_count;
    logic [4:0]             num_channels;
    logic [ENABLE_BITS-1:0] channel_enable;
  } cfg_t;

  typedef struct packed {
    logic signed [23:0] sample;
    logic [3:0]         out_channel;
    logic [23:0]        record_index;
    logic               last_in_record;
  } res_t;

endpackage

>>> rtl/core/srd24_regs.sv
// ----------------------------------------------------------------------------
// srd24_regs
// Configuration registers; flags a framing restart on every valid write.
// ----------------------------------------------------------------------------
module srd24_regs
  import srd24_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  wr_en,
  input  logic [CFG_IDX_W-1:0]  wr_index,
  input  logic [CFG_DATA_W-1:0] wr_data,
  output cfg_t                  cfg,
  output logic                  restart
);

  cfg_t cfg_r;
  logic hit;

  always_comb begin
    hit = 1'b0;
    unique case (wr_index)
      REG_HEADER_SKIP, REG_FIRST_RECORD, REG_RECORD_COUNT,
      REG_NUM_CHANNELS, REG_CHANNEL_ENABLE: hit = 1'b1;
      default: hit = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_r.header_skip    <= HEADER_SKIP_RST;
      cfg_r.first_record   <= FIRST_RECORD_RST;
      cfg_r.record_count   <= RECORD_COUNT_RST;
      cfg_r.num_channels   <= NUM_CHANNELS_RST;
      cfg_r.channel_enable <= CHANNEL_ENABLE_RST;
    end else if (wr_en) begin
      unique case (wr_index)
        REG_HEADER_SKIP:    cfg_r.header_skip    <= wr_data[7:0];
        REG_FIRST_RECORD:   cfg_r.first_record   <= wr_data[23:0];
        REG_RECORD_COUNT:   cfg_r.record_count   <= wr_data[23:0];
        REG_NUM_CHANNELS:   cfg_r.num_channels   <= wr_data[4:0];
        REG_CHANNEL_ENABLE: cfg_r.channel_enable <= wr_data[ENABLE_BITS-1:0];
        default: ;
      endcase
    end
  end

  assign cfg     = cfg_r;
  assign restart = wr_en & hit;

endmodule

>>> rtl/core/srd24_frame.sv
// ----------------------------------------------------------------------------
// srd24_frame
// Framing state and per-word decode: header skip, record skip, sample build.
// ----------------------------------------------------------------------------
module srd24_frame
  import srd24_pkg::*;
#(
  parameter int MAX_CHANNELS = 16
) (
  input  logic       clk,
  input  logic       rst,
  input  cfg_t       cfg,
  input  logic       restart,
  input  logic       step,
  input  logic [7:0] byte_d,
  output logic       ready,
  output res_t       res,
  output logic       res_hit
);

  localparam int NC_W  = $clog2(MAX_CHANNELS + 1);
  localparam int CHI_W = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam int POS_W = $clog2(4 + 3 * MAX_CHANNELS);
  localparam int EN_N  = (MAX_CHANNELS < ENABLE_BITS) ? MAX_CHANNELS : ENABLE_BITS;

  logic              reload;
  logic [7:0]        hdr_left;
  logic [23:0]       skip_rec;
  logic [POS_W-1:0]  pos;
  logic [1:0]        sub;
  logic [15:0]       low_bytes;
  logic [NC_W-1:0]   channel_pos;
  logic [3:0]        enabled_pos;
  logic [23:0]       records_done;
  logic              finished;

  logic [7:0]        hdr_left_next;
  logic [23:0]       skip_rec_next;
  logic [POS_W-1:0]  pos_next;
  logic [1:0]        sub_next;
  logic [15:0]       low_bytes_next;
  logic [NC_W-1:0]   channel_pos_next;
  logic [3:0]        enabled_pos_next;
  logic [23:0]       records_done_next;
  logic              finished_next;

  logic [NC_W-1:0]         nc;
  logic [POS_W-1:0]        data_end;
  logic [MAX_CHANNELS-1:0] ch_on;
  logic [MAX_CHANNELS-1:0] later;
  logic [23:0]             rec_inc;
  logic                    cur_on;

  always_comb begin
    if (cfg.num_channels == 5'd0) begin
      nc = NC_W'(1);
    end else if (32'(cfg.num_channels) > 32'(MAX_CHANNELS)) begin
      nc = NC_W'(MAX_CHANNELS);
    end else begin
      nc = NC_W'(cfg.num_channels);
    end
  end

  assign data_end = POS_W'(PREFIX_BYTES) + (POS_W'(nc) << 1) + POS_W'(nc);

  for (genvar g = 0; g < MAX_CHANNELS; g++) begin : g_chan
    if (g < EN_N) begin : g_en
      assign ch_on[g] = cfg.channel_enable[g] & (nc > NC_W'(g));
    end else begin : g_off
      assign ch_on[g] = 1'b0;
    end
    assign later[g] = ch_on[g] & (NC_W'(g) > channel_pos);
  end

  assign cur_on  = ch_on[channel_pos[CHI_W-1:0]];
  assign rec_inc = records_done + 24'd1;
  assign ready   = ~reload;

  always_comb begin
    hdr_left_next     = hdr_left;
    skip_rec_next     = skip_rec;
    pos_next          = pos;
    sub_next          = sub;
    low_bytes_next    = low_bytes;
    channel_pos_next  = channel_pos;
    enabled_pos_next  = enabled_pos;
    records_done_next = records_done;
    finished_next     = finished;
    res_hit           = 1'b0;
    res.sample         = {byte_d, low_bytes};
    res.out_channel    = enabled_pos;
    res.record_index   = records_done;
    res.last_in_record = ~|later;
    if (step && !finished) begin
      priority if (hdr_left != 8'd0) begin
        hdr_left_next = hdr_left - 8'd1;
      end else if (skip_rec != 24'd0) begin
        if (pos == data_end) begin
          pos_next      = '0;
          skip_rec_next = skip_rec - 24'd1;
        end else begin
          pos_next = pos + POS_W'(1);
        end
      end else if (pos < POS_W'(PREFIX_BYTES)) begin
        pos_next = pos + POS_W'(1);
      end else if (pos < data_end) begin
        pos_next = pos + POS_W'(1);
        unique case (sub)
          2'd0: begin
            low_bytes_next[7:0] = byte_d;
            sub_next            = 2'd1;
          end
          2'd1: begin
            low_bytes_next[15:8] = byte_d;
            sub_next             = 2'd2;
          end
          default: begin
            sub_next         = 2'd0;
            channel_pos_next = channel_pos + NC_W'(1);
            if (cur_on) begin
              res_hit          = 1'b1;
              enabled_pos_next = enabled_pos + 4'd1;
            end
          end
        endcase
      end else begin
        pos_next          = '0;
        sub_next          = 2'd0;
        channel_pos_next  = '0;
        enabled_pos_next  = 4'd0;
        records_done_next = rec_inc;
        finished_next     = (rec_inc >= cfg.record_count);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst || restart) begin
      reload       <= 1'b1;
      hdr_left     <= 8'd0;
      skip_rec     <= 24'd0;
      pos          <= '0;
      sub          <= 2'd0;
      channel_pos  <= '0;
      enabled_pos  <= 4'd0;
      records_done <= 24'd0;
      finished     <= 1'b1;
    end else if (reload) begin
      reload   <= 1'b0;
      hdr_left <= cfg.header_skip;
      skip_rec <= cfg.first_record;
      finished <= (cfg.record_count == 24'd0);
    end else begin
      hdr_left     <= hdr_left_next;
      skip_rec     <= skip_rec_next;
      pos          <= pos_next;
      sub          <= sub_next;
      channel_pos  <= channel_pos_next;
      enabled_pos  <= enabled_pos_next;
      records_done <= records_done_next;
      finished     <= finished_next;
    end
  end

  always_ff @(posedge clk) begin
    low_bytes <= low_bytes_next;
  end

  a_pos_in_record: assert property (@(posedge clk) disable iff (rst)
    pos <= data_end)
    else $error("record position beyond record end");

  a_no_word_when_done: assert property (@(posedge clk) disable iff (rst)
    (finished || reload) |-> !res_hit)
    else $error("word produced after framing finished");

  a_word_on_third_byte: assert property (@(posedge clk) disable iff (rst)
    res_hit |-> (step && sub == 2'd2 && hdr_left == 8'd0 && skip_rec == 24'd0))
    else $error("word produced outside a sample's last byte");

endmodule

>>> rtl/core/sample_record_deframer_24bit_unit.sv
// ----------------------------------------------------------------------------
// sample_record_deframer_24bit_unit
// Byte-stream deframer for records of little-endian 24-bit channel samples.
// ----------------------------------------------------------------------------
// path: an accepted byte is captured in the input register, then decoded into the
//   result register that drives the sample word outputs
// throughput: one byte per cycle while the output is not stalled; a held byte
//   waits after reset or a valid register write while the framing reloads
// reset: synchronous, active high; registers take their defaults and framing
//   reloads once reset is released, as after any valid register write
module sample_record_deframer_24bit_unit
  import srd24_pkg::*;
#(
  parameter int MAX_CHANNELS = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  wr_en,
  input  logic [CFG_IDX_W-1:0]  wr_index,
  input  logic [CFG_DATA_W-1:0] wr_data,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [7:0]            byte_in,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic signed [23:0]    sample,
  output logic [3:0]            out_channel,
  output logic [23:0]           record_index,
  output logic                  last_in_record
);

  cfg_t       cfg;
  logic       restart;
  logic       in_full;
  logic [7:0] in_byte;
  logic       adv;
  logic       step;
  logic       in_take;
  logic       frame_ready;
  res_t       res;
  logic       res_hit;
  res_t       out_r;

  srd24_regs u_regs (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (wr_en),
    .wr_index (wr_index),
    .wr_data  (wr_data),
    .cfg      (cfg),
    .restart  (restart)
  );

  srd24_frame #(
    .MAX_CHANNELS (MAX_CHANNELS)
  ) u_frame (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .restart (restart),
    .step    (step),
    .byte_d  (in_byte),
    .ready   (frame_ready),
    .res     (res),
    .res_hit (res_hit)
  );

  assign adv      = ~out_valid | ~out_stall;
  assign step     = in_full & adv & frame_ready;
  assign in_stall = in_full & ~(adv & frame_ready);
  assign in_take  = in_valid & ~in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (in_take) begin
        in_full <= 1'b1;
      end else if (step) begin
        in_full <= 1'b0;
      end
      if (adv) begin
        out_valid <= step & res_hit;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      in_byte <= byte_in;
    end
    if (step && res_hit) begin
      out_r <= res;
    end
  end

  assign sample         = out_r.sample;
  assign out_channel    = out_r.out_channel;
  assign record_index   = out_r.record_index;
  assign last_in_record = out_r.last_in_record;

endmodule
